// ----- design/assert_macros.svh -----
// Assertion macros shared by the frame decoder modules.
// No dependencies; included inside the module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the synchronous reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while the synchronous reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/vfd_pkg.sv -----
// Shared types and constants for the VADPCM frame decoder.
// No dependencies; imported by the controller, the datapath and the top level.
package vfd_pkg;

    localparam int BOOK_ENTRIES_DEF = 8;

    // Input tdata layout, lowest field first.
    localparam int COEF_ADDR_W  = 7;
    localparam int COEF_W       = 16;
    localparam int HEADER_W     = 8;
    localparam int PAYLOAD_W    = 64;
    localparam int S_TDATA_W    = 96;
    localparam int COEF_ADDR_LO = 0;
    localparam int COEF_VAL_LO  = COEF_ADDR_LO + COEF_ADDR_W;
    localparam int HEADER_LO    = COEF_VAL_LO + COEF_W;
    localparam int PAYLOAD_LO   = HEADER_LO + HEADER_W;

    localparam int SAMPLE_W     = 16;
    localparam int CODE_W       = 19;   // 4-bit code shifted left by up to 15
    localparam int ACC_W        = 32;
    localparam int ACC_SHIFT    = 11;

    localparam logic [2:0] SUB_LAST_SAMP = 3'd7;
    localparam logic [2:0] SUB_HIST_OLD  = 3'd6;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // Item kinds carried on tuser.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Multiplier operand source for one product term.
    typedef enum logic [1:0] {
        OP_OLDER,
        OP_NEWER,
        OP_CODE
    } t_opsel;

    // Controller to datapath commands.
    typedef struct packed {
        logic       start;     // latch a frame from the input transaction
        logic       wr;        // write one book coefficient
        logic       init;      // load the accumulator with the scaled code
        logic       issue;     // issue one product term into the MAC
        logic       emit;      // saturate and move the sample to the output
        logic       last;      // sixteenth sample of the frame
        logic [2:0] samp;      // sample index within the sub-frame
        logic       row;       // book row of the coefficient
        logic [2:0] col;       // book column of the coefficient
        t_opsel     opsel;
        logic [3:0] code_idx;  // code index within the frame
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic pipe_empty;      // no product term in flight
        logic out_free;        // output register can take a sample now
    } t_dp_stat;

endpackage

// ----- design/vfd_ctrl.sv -----
// Sequencing controller for the VADPCM frame decoder.
// Depends on vfd_pkg; drives the datapath through t_dp_cmd and reads t_dp_stat.
module vfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tuser,
    output logic             o_s_tready,
    input  vfd_pkg::t_dp_stat i_stat,
    output vfd_pkg::t_dp_cmd  o_cmd
);
    import vfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state     r_state;
    logic       r_sub;
    logic [2:0] r_samp;
    logic [3:0] r_term;

    logic       w_accept;
    logic [3:0] w_term_max;
    logic [3:0] w_k;
    logic [3:0] w_src;
    logic       w_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_term_max = {1'b0, r_samp} + 4'd1;
    // Term 2+k weights row 1 column k with code i-1-k of the sub-frame, i being the sample index.
    assign w_k        = r_term - 4'd2;
    assign w_src      = w_term_max - r_term;
    assign w_last     = r_sub & (r_samp == SUB_LAST_SAMP);

    always_comb begin
        o_cmd          = '0;
        o_cmd.samp     = r_samp;
        o_cmd.last     = w_last;
        o_cmd.col      = r_samp;
        o_cmd.opsel    = OP_OLDER;
        o_cmd.code_idx = {r_sub, r_samp};
        unique case (r_state)
            S_IDLE: begin
                o_cmd.start = w_accept & (i_s_tuser == ACT_DECODE);
                o_cmd.wr    = w_accept & (i_s_tuser == ACT_WRITE);
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                priority if (r_term == 4'd0) begin
                    o_cmd.row   = 1'b0;
                    o_cmd.opsel = OP_OLDER;
                end else if (r_term == 4'd1) begin
                    o_cmd.row   = 1'b1;
                    o_cmd.opsel = OP_NEWER;
                end else begin
                    o_cmd.row      = 1'b1;
                    o_cmd.col      = w_k[2:0];
                    o_cmd.opsel    = OP_CODE;
                    o_cmd.code_idx = {r_sub, w_src[2:0]};
                end
            end
            S_WAIT: begin
                o_cmd.emit = i_stat.pipe_empty & i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= 1'b0;
            r_samp  <= '0;
            r_term  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_s_tuser == ACT_DECODE) begin
                        r_state <= S_INIT;
                        r_sub   <= 1'b0;
                        r_samp  <= '0;
                    end
                end
                S_INIT: begin
                    r_term  <= '0;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_term <= r_term + 4'd1;
                    if (r_term == w_term_max) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (i_stat.pipe_empty && i_stat.out_free) begin
                        if (r_samp == SUB_LAST_SAMP) begin
                            r_samp <= '0;
                            if (r_sub) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_sub   <= 1'b1;
                                r_state <= S_INIT;
                            end
                        end else begin
                            r_samp  <= r_samp + 3'd1;
                            r_state <= S_INIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_decode_starts, i_clk, i_rst_n, o_cmd.start, r_state == S_INIT && r_samp == 3'd0 && r_sub == 1'b0)
    `ASSERT_IMPLY(a_term_bound, i_clk, i_rst_n, r_state == S_ISSUE, r_term <= w_term_max)
    `ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, o_cmd.emit && o_cmd.last, r_state == S_IDLE)

endmodule

// ----- design/vfd_dpath.sv -----
// Datapath of the VADPCM frame decoder: code book memory, three-stage MAC,
// history and output register. Depends on vfd_pkg; commanded by vfd_ctrl.
module vfd_dpath #(
    parameter int BOOK_ENTRIES = vfd_pkg::BOOK_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vfd_pkg::t_dp_cmd               i_cmd,
    output vfd_pkg::t_dp_stat              o_stat,
    input  logic [vfd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [vfd_pkg::SAMPLE_W-1:0]   o_m_tdata,
    output logic                           o_m_tlast
);
    import vfd_pkg::*;

    localparam int          DEPTH   = BOOK_ENTRIES * 16;
    localparam int          AW      = $clog2(DEPTH);
    localparam logic [8:0]  DEPTH_L = 9'(DEPTH);
    localparam logic [3:0]  ENT_MAX = 4'(BOOK_ENTRIES - 1);

    logic signed [COEF_W-1:0] mem [DEPTH];

    logic [COEF_ADDR_W-1:0]   w_waddr_in;
    logic signed [COEF_W-1:0] w_wdata;
    logic [HEADER_W-1:0]      w_header;
    logic [7:0]               w_waddr8;
    logic [7:0]               w_raddr8;
    logic                     w_we;
    logic signed [CODE_W-1:0] w_code;
    logic signed [CODE_W-1:0] w_opnd;
    logic signed [CODE_W+COEF_W-1:0] w_prod_full;
    logic signed [20:0]       w_shr;
    logic signed [SAMPLE_W-1:0] w_sat;

    logic [PAYLOAD_W-1:0]     r_payload;
    logic [3:0]               r_shift;
    logic [3:0]               r_entry;
    logic signed [COEF_W-1:0] r_rdata;
    logic                     r_s1_valid;
    logic signed [CODE_W-1:0] r_s1_opnd;
    logic                     r_s2_valid;
    logic [ACC_W-1:0]         r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic signed [SAMPLE_W-1:0] r_hist_old;
    logic signed [SAMPLE_W-1:0] r_hist_new;
    logic signed [SAMPLE_W-1:0] r_hist_pend;
    logic                     r_out_valid;
    logic [SAMPLE_W-1:0]      r_out_data;
    logic                     r_out_last;

    // Signed nibble of the payload, scaled by the frame's code shift.
    function automatic logic signed [CODE_W-1:0] code_of(
        input logic [PAYLOAD_W-1:0] payload,
        input logic [3:0]           shift,
        input logic [3:0]           idx
    );
        logic [5:0]               top;
        logic [3:0]               nib;
        logic signed [CODE_W-1:0] v;
        top = 6'd63 - {idx, 2'b00};
        nib = payload[top -: 4];
        v   = {{(CODE_W-4){nib[3]}}, nib};
        return v <<< shift;
    endfunction

    assign w_waddr_in = i_s_tdata[COEF_ADDR_LO +: COEF_ADDR_W];
    assign w_wdata    = i_s_tdata[COEF_VAL_LO +: COEF_W];
    assign w_header   = i_s_tdata[HEADER_LO +: HEADER_W];
    assign w_waddr8   = {1'b0, w_waddr_in};
    assign w_we       = i_cmd.wr & ({2'b00, w_waddr_in} < DEPTH_L);
    assign w_raddr8   = {r_entry, i_cmd.row, i_cmd.col};

    assign w_code = code_of(r_payload, r_shift, i_cmd.code_idx);

    always_comb begin
        unique case (i_cmd.opsel)
            OP_OLDER: w_opnd = {{(CODE_W-SAMPLE_W){r_hist_old[SAMPLE_W-1]}}, r_hist_old};
            OP_NEWER: w_opnd = {{(CODE_W-SAMPLE_W){r_hist_new[SAMPLE_W-1]}}, r_hist_new};
            OP_CODE:  w_opnd = w_code;
            default:  w_opnd = '0;
        endcase
    end

    assign w_prod_full = r_s1_opnd * r_rdata;

    // Arithmetic shift by 11, then clamp to the 16-bit range.
    assign w_shr = r_acc[ACC_W-1:ACC_SHIFT];
    always_comb begin
        if (w_shr[20:15] == 6'b000000 || w_shr[20:15] == 6'b111111) begin
            w_sat = w_shr[SAMPLE_W-1:0];
        end else if (w_shr[20]) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = SAT_MAX;
        end
    end

    assign o_stat.pipe_empty = ~r_s1_valid & ~r_s2_valid;
    assign o_stat.out_free   = ~r_out_valid | i_m_tready;

    // Code book memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr8[AW-1:0]] <= w_wdata;
        end
        r_rdata <= mem[w_raddr8[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_payload <= i_s_tdata[PAYLOAD_LO +: PAYLOAD_W];
            r_shift   <= w_header[7:4];
            r_entry   <= (w_header[3:0] > ENT_MAX) ? ENT_MAX : w_header[3:0];
        end
        r_s1_opnd <= w_opnd;
        r_prod    <= w_prod_full[ACC_W-1:0];
        if (i_cmd.init) begin
            r_acc <= {{(ACC_W-CODE_W-ACC_SHIFT){w_code[CODE_W-1]}}, w_code,
                      {ACC_SHIFT{1'b0}}};
        end else if (r_s2_valid) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.emit) begin
            r_out_data <= w_sat;
            r_out_last <= i_cmd.last;
            if (i_cmd.samp == SUB_HIST_OLD) begin
                r_hist_pend <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist_old  <= '0;
            r_hist_new  <= '0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit && i_cmd.samp == SUB_LAST_SAMP) begin
                r_hist_old <= r_hist_pend;
                r_hist_new <= w_sat;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_emit_drained, i_clk, i_rst_n, i_cmd.emit, !r_s1_valid && !r_s2_valid)
    `ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, o_m_tvalid)

endmodule

// ----- design/vadpcm_frame_decoder_unit.sv -----
// Top level of the order-2 VADPCM frame decoder.
// Depends on vfd_pkg, vfd_ctrl and vfd_dpath.
//
// The unit takes one transaction on the slave stream and, for a decode item,
// returns sixteen signed 16-bit samples on the master stream, tlast marking
// the sixteenth. tuser selects the item kind: 0 writes one coefficient into
// the code book (BOOK_ENTRIES entries of two rows of eight coefficients),
// 1 decodes a 9-byte frame whose header high nibble is the code shift and
// whose low nibble picks the book entry, clamped to the last entry. A write
// beyond the book is ignored, and a frame must only use entries that have
// been written. History carries from frame to frame and is cleared by reset.
// A write item does not take the unit out of its idle state. A decode item
// occupies the unit until its last sample has moved to the output register;
// all products run through a single multiplier fed by the single read port
// of the code book, one product a cycle; sample i of a sub-frame needs i+2
// products, preceded by loading the accumulator and followed by draining the
// read-multiply-add pipeline. The output register lets the last sample of a
// frame wait while the next item is already accepted; a stalled master side
// holds the decoder in place.
module vadpcm_frame_decoder_unit #(
    parameter int BOOK_ENTRIES = vfd_pkg::BOOK_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: coef_address[6:0], coef_value[22:7],
    // frame_header[30:23], frame_payload[94:31], zero pad [95]
    input  logic [vfd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: action (0 = coefficient write, 1 = frame decode)
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: sample[15:0]
    output logic [vfd_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    // tlast: last_sample
    output logic                          m_axis_tlast
);
    import vfd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller sequences samples and product terms of each frame.
    vfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the book, the MAC, the history and the result register.
    vfd_dpath #(
        .BOOK_ENTRIES (BOOK_ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule
